// ===== hdl/stma_pkg.sv =====
// ----------------------------------------------------------------------------
// stma_pkg
// Shared widths, command codes and interface structs of the sorted term
// merge and add unit.
// ----------------------------------------------------------------------------
package stma_pkg;

	localparam int MAX_TERMS = 32;
	localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);

	localparam int COEF_W    = 32;
	localparam int EXP_W     = 16;
	localparam int SUM_W     = COEF_W + 1;
	localparam int ENTRY_W   = COEF_W + EXP_W;

	localparam int S_DATA_W  = ((COEF_W + EXP_W + 7) / 8) * 8;
	localparam int M_DATA_W  = ((SUM_W + EXP_W + 7) / 8) * 8;
	localparam int CMD_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND_A = 2'd0,
		CMD_APPEND_B = 2'd1,
		CMD_MERGE    = 2'd2
	} cmd_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [ENTRY_W-1:0] data;
	} wr_port_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] len_a;
		logic [CNT_W-1:0] len_b;
		logic             dropped;
	} merge_start_t;

endpackage

// ===== hdl/stma_ram.sv =====
// ----------------------------------------------------------------------------
// stma_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module stma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/stma_loader.sv =====
// ----------------------------------------------------------------------------
// stma_loader
// Handles append and merge commands: keeps the fill counts of both lists and
// the overflow flag, drives the list write ports and starts a merge.
// ----------------------------------------------------------------------------
module stma_loader (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [stma_pkg::CMD_W-1:0]     cmd,
	input  logic [stma_pkg::ENTRY_W-1:0]   term,
	output stma_pkg::wr_port_t             wr_a,
	output stma_pkg::wr_port_t             wr_b,
	output stma_pkg::merge_start_t         start
);

	logic [stma_pkg::CNT_W-1:0] count_a_q;
	logic [stma_pkg::CNT_W-1:0] count_b_q;
	logic                       overflow_q;
	logic                       full_a;
	logic                       full_b;

	assign full_a = (count_a_q == stma_pkg::CNT_W'(stma_pkg::MAX_TERMS));
	assign full_b = (count_b_q == stma_pkg::CNT_W'(stma_pkg::MAX_TERMS));

	always_comb begin
		wr_a.en       = 1'b0;
		wr_a.addr     = count_a_q[stma_pkg::IDX_W-1:0];
		wr_a.data     = term;
		wr_b.en       = 1'b0;
		wr_b.addr     = count_b_q[stma_pkg::IDX_W-1:0];
		wr_b.data     = term;
		start.start   = 1'b0;
		start.len_a   = count_a_q;
		start.len_b   = count_b_q;
		start.dropped = overflow_q;
		if (accept) begin
			case (stma_pkg::cmd_t'(cmd))
				stma_pkg::CMD_APPEND_A: wr_a.en = !full_a;
				stma_pkg::CMD_APPEND_B: wr_b.en = !full_b;
				stma_pkg::CMD_MERGE:    start.start = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			case (stma_pkg::cmd_t'(cmd))
				stma_pkg::CMD_APPEND_A: begin
					if (full_a) overflow_q <= 1'b1;
					else count_a_q <= count_a_q + 1'b1;
				end
				stma_pkg::CMD_APPEND_B: begin
					if (full_b) overflow_q <= 1'b1;
					else count_b_q <= count_b_q + 1'b1;
				end
				stma_pkg::CMD_MERGE: begin
					// The merge takes a snapshot, so the lists are empty from here on.
					count_a_q  <= '0;
					count_b_q  <= '0;
					overflow_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/stma_merge.sv =====
// ----------------------------------------------------------------------------
// stma_merge
// Walks both list memories from their heads, emits the term with the greater
// exponent or the sum on equal exponents, one term per cycle while the output
// is taken, into an output register.
// ----------------------------------------------------------------------------
module stma_merge (
	input  logic                           clk,
	input  logic                           arst_n,
	input  stma_pkg::merge_start_t         start,
	input  logic [stma_pkg::ENTRY_W-1:0]   rdata_a,
	input  logic [stma_pkg::ENTRY_W-1:0]   rdata_b,
	output logic [stma_pkg::IDX_W-1:0]     raddr_a,
	output logic [stma_pkg::IDX_W-1:0]     raddr_b,
	output logic                           busy,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [stma_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	output logic                           m_tuser
);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t                      state_q;
	logic [stma_pkg::CNT_W-1:0]  ia_q;
	logic [stma_pkg::CNT_W-1:0]  ib_q;
	logic [stma_pkg::CNT_W-1:0]  len_a_q;
	logic [stma_pkg::CNT_W-1:0]  len_b_q;
	logic                        flag_q;

	logic signed [stma_pkg::EXP_W-1:0]  ea;
	logic signed [stma_pkg::EXP_W-1:0]  eb;
	logic signed [stma_pkg::SUM_W-1:0]  ca;
	logic signed [stma_pkg::SUM_W-1:0]  cb;
	logic                        a_has;
	logic                        b_has;
	logic                        adv_a;
	logic                        adv_b;
	logic                        fire;
	logic [stma_pkg::CNT_W-1:0]  ia_nxt;
	logic [stma_pkg::CNT_W-1:0]  ib_nxt;
	logic                        done;
	logic signed [stma_pkg::SUM_W-1:0]  sum;
	logic [stma_pkg::EXP_W-1:0]  ex;

	assign ea = $signed(rdata_a[stma_pkg::ENTRY_W-1:stma_pkg::COEF_W]);
	assign eb = $signed(rdata_b[stma_pkg::ENTRY_W-1:stma_pkg::COEF_W]);
	assign ca = stma_pkg::SUM_W'($signed(rdata_a[stma_pkg::COEF_W-1:0]));
	assign cb = stma_pkg::SUM_W'($signed(rdata_b[stma_pkg::COEF_W-1:0]));

	assign a_has = (ia_q < len_a_q);
	assign b_has = (ib_q < len_b_q);
	assign adv_a = a_has && (!b_has || (ea >= eb));
	assign adv_b = b_has && (!a_has || (eb >= ea));

	assign fire = (state_q == ST_WALK) && (!m_tvalid || m_tready);

	always_comb begin
		ia_nxt = ia_q;
		ib_nxt = ib_q;
		if (fire) begin
			ia_nxt = ia_q + stma_pkg::CNT_W'(adv_a);
			ib_nxt = ib_q + stma_pkg::CNT_W'(adv_b);
		end
		if (adv_a && adv_b) sum = ca + cb;
		else if (adv_a) sum = ca;
		else sum = cb;
		ex = adv_a ? ea : eb;
	end

	assign done = (ia_nxt >= len_a_q) && (ib_nxt >= len_b_q);

	// Reading at the next position keeps the registered read data lined up
	// with the pointers, so a term can leave every cycle that the output is taken.
	assign raddr_a = (state_q == ST_WALK) ? ia_nxt[stma_pkg::IDX_W-1:0] : '0;
	assign raddr_b = (state_q == ST_WALK) ? ib_nxt[stma_pkg::IDX_W-1:0] : '0;
	assign busy    = (state_q == ST_WALK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ia_q     <= '0;
			ib_q     <= '0;
			len_a_q  <= '0;
			len_b_q  <= '0;
			flag_q   <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
			m_tuser  <= 1'b0;
		end else begin
			if (m_tready && !fire) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					ia_q <= '0;
					ib_q <= '0;
					if (start.start && (start.len_a != '0 || start.len_b != '0)) begin
						len_a_q <= start.len_a;
						len_b_q <= start.len_b;
						flag_q  <= start.dropped;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (fire) begin
						ia_q     <= ia_nxt;
						ib_q     <= ib_nxt;
						m_tvalid <= 1'b1;
						m_tdata  <= stma_pkg::M_DATA_W'({ex, sum});
						m_tlast  <= done;
						m_tuser  <= flag_q;
						if (done) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/sorted_term_merge_add_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_term_merge_add_unit
// Adds two sparse polynomials held as term lists in two list memories.
// ----------------------------------------------------------------------------
// An append transaction (tuser 0 for list A, 1 for list B) writes the term at
// the tail of its list; a term beyond 32 per list is dropped and sets the drop
// flag that travels with every result of the next merge. A merge transaction
// (tuser 2) walks both lists, greater exponent first, equal exponents summed
// into one term, and empties both lists. It delivers one term per cycle while
// the output is taken, len_a + len_b terms at most; the first term reaches the
// output register after the merge has entered its walk state, and the rate is
// set by the single read port of each list memory. No input is taken while a
// merge walks; the input is ready again as soon as the final term sits in the
// output register.
module sorted_term_merge_add_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0 up: coefficient[31:0], exponent[47:32].
	input  logic [stma_pkg::S_DATA_W-1:0]  s_tdata,
	// Fields from bit 0 up: command[1:0].
	input  logic [stma_pkg::CMD_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0 up: sum_coefficient[32:0], term_exponent[48:33], zeros.
	output logic [stma_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	// Fields from bit 0 up: dropped_terms[0].
	output logic                           m_tuser
);

	stma_pkg::wr_port_t                 wr_a;
	stma_pkg::wr_port_t                 wr_b;
	stma_pkg::merge_start_t             start;
	logic [stma_pkg::ENTRY_W-1:0]       rdata_a;
	logic [stma_pkg::ENTRY_W-1:0]       rdata_b;
	logic [stma_pkg::IDX_W-1:0]         raddr_a;
	logic [stma_pkg::IDX_W-1:0]         raddr_b;
	logic                               busy;

	assign s_tready = !busy;

	stma_loader u_loader (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (s_tvalid && s_tready),
		.cmd    (s_tuser),
		.term   (s_tdata[stma_pkg::ENTRY_W-1:0]),
		.wr_a   (wr_a),
		.wr_b   (wr_b),
		.start  (start)
	);

	stma_ram #(
		.WIDTH (stma_pkg::ENTRY_W),
		.DEPTH (stma_pkg::MAX_TERMS)
	) u_list_a (
		.clk   (clk),
		.we    (wr_a.en),
		.waddr (wr_a.addr),
		.wdata (wr_a.data),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	stma_ram #(
		.WIDTH (stma_pkg::ENTRY_W),
		.DEPTH (stma_pkg::MAX_TERMS)
	) u_list_b (
		.clk   (clk),
		.we    (wr_b.en),
		.waddr (wr_b.addr),
		.wdata (wr_b.data),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	stma_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.rdata_a  (rdata_a),
		.rdata_b  (rdata_b),
		.raddr_a  (raddr_a),
		.raddr_b  (raddr_b),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== hdl/stma_checker.sv =====
// ----------------------------------------------------------------------------
// stma_checker
// Port-level checks of the sorted term merge and add unit, bound to the top.
// ----------------------------------------------------------------------------
module stma_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [stma_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                           m_tlast,
	input  logic                           m_tuser
);

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

	// A pending term that is not the final one means the merge still walks.
	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready during a merge");

	// Once the final term is taken the unit takes input again, unless a further
	// merge has already started and delivers its first term.
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && !(s_tvalid && s_tready)
			|=> s_tready || m_tvalid)
		else $error("input not ready after final term");

	// A new result only appears out of a merge walk, never from an append.
	a_result_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result produced outside a merge");

endmodule

bind sorted_term_merge_add_unit stma_checker u_stma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
